// File: design/psa_pkg.sv
// Shared types, constants and helpers for the paged slot allocator.
// No dependencies; every other design file refers to this package by scope.
package psa_pkg;

    localparam int PAGE_COUNT = 16;
    localparam int PAGE_W     = 4;
    localparam int MAX_SLOTS  = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int PIU_W      = 5;

    // Page 0 is the file header page and doubles as the "no page" link
    localparam logic [PAGE_W-1:0] NO_PAGE       = 4'd0;
    localparam logic [PAGE_W-1:0] FILE_HDR_PAGE = 4'd0;

    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_RECORD    = 2'd1,
        ST_NO_PAGE      = 2'd2,
        ST_OUT_OF_PAGES = 2'd3
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        command;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } result_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } find_t;

    // Clamp the slots-per-page register to 1..MAX_SLOTS
    function automatic logic [CNT_W-1:0] eff_slots(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = 7'd1;
        end
        else if (v > CNT_W'(MAX_SLOTS))
        begin
            r = CNT_W'(MAX_SLOTS);
        end
        return r;
    endfunction

endpackage

// File: design/psa_slot_find.sv
// Lowest free slot search over one page bitmap, limited to the slots in use.
// Depends on psa_pkg.
module psa_slot_find (
    input  logic [psa_pkg::MAX_SLOTS-1:0] bitmap,
    input  logic [psa_pkg::CNT_W-1:0]     spp,
    output psa_pkg::find_t                find
);

    logic [psa_pkg::MAX_SLOTS-1:0] mask;
    logic [psa_pkg::MAX_SLOTS-1:0] free_bits;
    logic [psa_pkg::MAX_SLOTS-1:0] lowest;
    logic [psa_pkg::SLOT_W-1:0]    slot_idx;

    // Build the in-use slot mask
    always_comb
    begin
        for (int i = 0; i < psa_pkg::MAX_SLOTS; i++)
        begin
            mask[i] = (psa_pkg::CNT_W'(i) < spp);
        end
    end

    // Isolate the lowest clear bit with one wide add
    assign free_bits = ~bitmap & mask;
    assign lowest    = free_bits & (~free_bits + psa_pkg::MAX_SLOTS'(1));

    // Encode the one-hot bit to a slot index
    always_comb
    begin
        slot_idx = '0;
        for (int i = 0; i < psa_pkg::MAX_SLOTS; i++)
        begin
            slot_idx = slot_idx | (lowest[i] ? psa_pkg::SLOT_W'(i) : '0);
        end
    end

    assign find.found = |free_bits;
    assign find.slot  = slot_idx;

endmodule

// File: design/psa_core.sv
// Page table state (bitmaps, fill counts, free links, list head, page count)
// and the single-pass update for one registered command. Depends on psa_pkg
// and psa_slot_find.
module psa_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  psa_pkg::item_t            item,
    input  logic [psa_pkg::CNT_W-1:0] spp,
    output psa_pkg::result_t          res
);

    logic [psa_pkg::MAX_SLOTS-1:0] bitmap_reg [psa_pkg::PAGE_COUNT];
    logic [psa_pkg::CNT_W-1:0]     fill_reg   [psa_pkg::PAGE_COUNT];
    logic [psa_pkg::PAGE_W-1:0]    link_reg   [psa_pkg::PAGE_COUNT];
    logic [psa_pkg::PAGE_W-1:0]    head_reg;
    logic [psa_pkg::PAGE_W-1:0]    head_next;
    logic [psa_pkg::PIU_W-1:0]     piu_reg;
    logic [psa_pkg::PIU_W-1:0]     piu_next;

    logic                          is_insert;
    logic                          head_empty;
    logic                          file_full;
    logic [psa_pkg::PAGE_W-1:0]    ins_page;
    logic [psa_pkg::PAGE_W-1:0]    rd_page;
    logic [psa_pkg::MAX_SLOTS-1:0] bm_rd;
    logic [psa_pkg::CNT_W-1:0]     fill_rd;
    logic [psa_pkg::PAGE_W-1:0]    link_rd;
    logic [psa_pkg::CNT_W-1:0]     fill_inc;
    logic [psa_pkg::CNT_W-1:0]     fill_dec;
    psa_pkg::find_t                find;

    logic                          wr_en;
    logic [psa_pkg::MAX_SLOTS-1:0] wr_bitmap;
    logic [psa_pkg::CNT_W-1:0]     wr_fill;
    logic [psa_pkg::PAGE_W-1:0]    wr_link;

    // Select the page to work on: the item page, or for an insert the list head (a fresh page when the list is empty)
    assign is_insert  = (item.command == psa_pkg::CMD_INSERT);
    assign head_empty = (head_reg == psa_pkg::NO_PAGE) ||
                        ({1'b0, head_reg} >= piu_reg);
    assign file_full  = (piu_reg >= psa_pkg::PIU_W'(psa_pkg::PAGE_COUNT));
    assign ins_page   = head_empty ? piu_reg[psa_pkg::PAGE_W-1:0] : head_reg;
    assign rd_page    = is_insert ? ins_page : item.page;

    // Read the selected page; a fresh page reads as cleared
    always_comb
    begin
        if (is_insert && head_empty)
        begin
            bm_rd   = '0;
            fill_rd = '0;
            link_rd = psa_pkg::NO_PAGE;
        end
        else
        begin
            bm_rd   = bitmap_reg[rd_page];
            fill_rd = fill_reg[rd_page];
            link_rd = link_reg[rd_page];
        end
    end

    assign fill_inc = (fill_rd == psa_pkg::CNT_MAX) ? fill_rd : fill_rd + 1'b1;
    assign fill_dec = (fill_rd == '0) ? fill_rd : fill_rd - 1'b1;

    psa_slot_find u_find (
        .bitmap (bm_rd),
        .spp    (spp),
        .find   (find)
    );

    // Decide the result and the write-back for this command
    always_comb
    begin
        wr_en      = 1'b0;
        wr_bitmap  = bm_rd;
        wr_fill    = fill_rd;
        wr_link    = link_rd;
        head_next  = head_reg;
        piu_next   = piu_reg;
        res.status = psa_pkg::ST_OK;
        res.page   = item.page;
        res.slot   = item.slot;

        if (is_insert)
        begin
            res.page = '0;
            res.slot = '0;
            if (head_empty && file_full)
            begin
                res.status = psa_pkg::ST_OUT_OF_PAGES;
            end
            else
            begin
                if (head_empty)
                begin
                    piu_next = piu_reg + 1'b1;
                    wr_en    = 1'b1;
                end
                if (!find.found)
                begin
                    // Head page has no room left under the current limit: unlink it
                    head_next  = link_rd;
                    res.status = psa_pkg::ST_OUT_OF_PAGES;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_bitmap = bm_rd | (psa_pkg::MAX_SLOTS'(1) << find.slot);
                    wr_fill   = fill_inc;
                    head_next = (fill_inc >= spp) ? link_rd : ins_page;
                    res.page  = ins_page;
                    res.slot  = find.slot;
                end
            end
        end
        else if ((item.page == psa_pkg::FILE_HDR_PAGE) ||
                 ({1'b0, item.page} >= piu_reg))
        begin
            res.status = psa_pkg::ST_NO_PAGE;
        end
        else if (({1'b0, item.slot} >= spp) || !bm_rd[item.slot])
        begin
            res.status = psa_pkg::ST_NO_RECORD;
        end
        else if (item.command == psa_pkg::CMD_DELETE)
        begin
            wr_en     = 1'b1;
            wr_bitmap = bm_rd & ~(psa_pkg::MAX_SLOTS'(1) << item.slot);
            wr_fill   = fill_dec;
            if (fill_rd >= spp)
            begin
                // Relink a full page at the head of the free list
                wr_link   = head_reg;
                head_next = item.page;
            end
        end
    end

    // Commit the page write and list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psa_pkg::PAGE_COUNT; i++)
            begin
                bitmap_reg[i] <= '0;
                fill_reg[i]   <= '0;
                link_reg[i]   <= psa_pkg::NO_PAGE;
            end
            head_reg <= psa_pkg::NO_PAGE;
            piu_reg  <= psa_pkg::PIU_W'(1);
        end
        else if (item.valid)
        begin
            if (wr_en)
            begin
                bitmap_reg[rd_page] <= wr_bitmap;
                fill_reg[rd_page]   <= wr_fill;
                link_reg[rd_page]   <= wr_link;
            end
            head_reg <= head_next;
            piu_reg  <= piu_next;
        end
    end

endmodule

// File: design/paged_slot_allocator_top.sv
// Top level of the paged slot allocator: command input register, config
// register, result register. Depends on psa_pkg and psa_core.
//
//  channel   | signals                                   | transaction when
//  ----------+-------------------------------------------+------------------------
//  command   | start, busy, command, page_number,        | start high, busy low
//            | slot_number                               |
//  config    | cfg_valid, cfg_ready, cfg_data            | cfg_valid and cfg_ready
//  result    | done, status, result_page, result_slot    | done high (one cycle)
//
// One command is taken every cycle. Each one passes through the input register,
// where the page read, slot search and write-back complete, and then the result
// register, which drives the done strobe and the result outputs.
// Reset is asynchronous, active low: all pages but the header page absent,
// free list empty, slots per page 64. Busy stays low; the receiver cannot stall.
module paged_slot_allocator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [3:0] page_number,
    input  logic [5:0] slot_number,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data,
    output logic       done,
    output logic [1:0] status,
    output logic [3:0] result_page,
    output logic [5:0] result_slot
);

    logic                      in_valid_reg;
    logic [1:0]                cmd_reg;
    logic [3:0]                page_reg;
    logic [5:0]                slot_reg;
    logic [psa_pkg::CNT_W-1:0] spp_reg;
    logic [psa_pkg::CNT_W-1:0] spp_eff;
    logic                      done_reg;
    psa_pkg::result_t          res_reg;
    psa_pkg::result_t          res_next;
    psa_pkg::item_t            item;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Hold the slots-per-page register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= psa_pkg::CNT_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            spp_reg <= cfg_data;
        end
    end

    assign spp_eff = psa_pkg::eff_slots(spp_reg);

    // Capture each command transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg  <= command;
            page_reg <= page_number;
            slot_reg <= slot_number;
        end
    end

    assign item.valid   = in_valid_reg;
    assign item.command = cmd_reg;
    assign item.page    = page_reg;
    assign item.slot    = slot_reg;

    psa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .spp   (spp_eff),
        .res   (res_next)
    );

    // Register the result and strobe it for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done        = done_reg;
    assign status      = res_reg.status;
    assign result_page = res_reg.page;
    assign result_slot = res_reg.slot;

endmodule
